// File: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

	localparam int DEF_WIDTH = 32;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_NEXT,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} state_t;

	// Operand selection for the modular multiplier
	typedef enum logic [1:0] {
		MM_REDUCE,
		MM_MUL,
		MM_SQR
	} mm_op_t;

	typedef struct packed {
		logic   load;
		logic   start;
		mm_op_t op;
		logic   wr_a;
		logic   wr_y;
		logic   shift_e;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mm_done;
		logic e_zero;
		logic e_lsb;
		logic e_last;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/mexp_base_if.sv
// Input channel carrying one base value per transfer.
interface mexp_base_if import mexp_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base;

	modport source (output valid, output base, input ready);
	modport sink   (input valid, input base, output ready);
endinterface

// File: rtl/mexp_result_if.sv
// Output channel carrying one power_mod result per transfer.
interface mexp_result_if import mexp_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] power_mod;

	modport source (output valid, output power_mod, input ready);
	modport sink   (input valid, input power_mod, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// Sequence: the base is reduced first; below the highest set exponent bit, each bit
// takes a square, with a multiply before it when the bit is set; the highest set
// bit takes a multiply only, no square; then the result goes to the output.
// The multiplier handles one multiplier bit per cycle.
// One item in work at a time; the next is taken while the last result waits at the output.
// Reset (arst_n low, asynchronous): exponent 0, modulus 1, controller idle, output empty.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-1:0]     wr_data,
	mexp_base_if.sink            req,
	mexp_result_if.source        rsp
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mexp_dp #(.WIDTH(WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.base      (req.base),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.power_mod (rsp.power_mod)
	);

endmodule

// File: rtl/mexp_mulmod.sv
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod import mexp_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] x,      // multiplicand, must be below n
	input  logic [WIDTH-1:0] y,      // multiplier, any value
	input  logic [WIDTH-1:0] n,
	output logic             done,
	output logic [WIDTH-1:0] p
);
	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] acc_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] n1;
	logic [WIDTH+1:0] n2;
	logic [WIDTH+1:0] diff1;
	logic [WIDTH+1:0] diff2;
	logic [WIDTH-1:0] acc_nx;

	// acc*2 + bit*x stays below 3n: subtract n or 2n, chosen in parallel
	always_comb begin
		sum   = {1'b0, acc_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
		n1    = {2'b00, n};
		n2    = {1'b0, n, 1'b0};
		diff1 = sum - n1;
		diff2 = sum - n2;
		if (sum >= n2) begin
			acc_nx = diff2[WIDTH-1:0];
		end else if (sum >= n1) begin
			acc_nx = diff1[WIDTH-1:0];
		end else begin
			acc_nx = sum[WIDTH-1:0];
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and accumulator, multiplier scanned MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			y_q   <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// File: rtl/mexp_dp.sv
// Datapath: config registers, exponent shifter, operands and result register.
module mexp_dp import mexp_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic [WIDTH-1:0]     base,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WIDTH-1:0]     power_mod
);
	localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] res_q;
	logic             out_valid_q;

	logic             mm_done;
	logic [WIDTH-1:0] mm_p;
	logic [WIDTH-1:0] mm_x;
	logic [WIDTH-1:0] mm_y;

	// Configuration writes; a zero modulus is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= ONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_EXPONENT: exponent_q <= wr_data;
				REG_MODULUS: begin
					if (wr_data != '0) begin
						modulus_q <= wr_data;
					end
				end
				default: ;
			endcase
		end
	end

	// Multiplier operands; the first pass reduces the base as base * 1 mod n
	always_comb begin
		case (cmd.op)
			MM_REDUCE: begin
				mm_x = (modulus_q == ONE) ? '0 : ONE;
				mm_y = base;
			end
			MM_MUL: begin
				mm_x = a_q;
				mm_y = y_q;
			end
			MM_SQR: begin
				mm_x = a_q;
				mm_y = a_q;
			end
			default: begin
				mm_x = '0;
				mm_y = '0;
			end
		endcase
	end

	mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.x      (mm_x),
		.y      (mm_y),
		.n      (modulus_q),
		.done   (mm_done),
		.p      (mm_p)
	);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= exponent_q;
			y_q <= ONE;
		end else begin
			if (cmd.shift_e) begin
				e_q <= e_q >> 1;
			end
			if (cmd.wr_y) begin
				y_q <= mm_p;
			end
		end
		if (cmd.wr_a) begin
			a_q <= mm_p;
		end
		if (cmd.out_load) begin
			res_q <= y_q;
		end
	end

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.mm_done  = mm_done;
		sts.e_zero   = (e_q == '0);
		sts.e_lsb    = e_q[0];
		sts.e_last   = (e_q[WIDTH-1:1] == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign power_mod = res_q;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences reduction, multiply and square steps per exponent bit.
module mexp_ctrl import mexp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);
	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (sts.mm_done) begin
					state_nx = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sts.e_zero) begin
					state_nx = ST_FINISH;
				end else if (sts.e_lsb) begin
					state_nx = ST_MUL;
				end else begin
					state_nx = ST_SQR;
				end
			end
			ST_MUL: begin
				if (sts.mm_done) begin
					state_nx = sts.e_last ? ST_FINISH : ST_SQR;
				end
			end
			ST_SQR: begin
				if (sts.mm_done) begin
					state_nx = ST_NEXT;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.op       = MM_REDUCE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					cmd.start = 1'b1;
					cmd.op    = MM_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.wr_a = sts.mm_done;
			end
			ST_NEXT: begin
				if (!sts.e_zero) begin
					cmd.start = 1'b1;
					cmd.op    = sts.e_lsb ? MM_MUL : MM_SQR;
				end
			end
			ST_MUL: begin
				if (sts.mm_done) begin
					cmd.wr_y = 1'b1;
					if (!sts.e_last) begin
						cmd.start = 1'b1;
						cmd.op    = MM_SQR;
					end
				end
			end
			ST_SQR: begin
				if (sts.mm_done) begin
					cmd.wr_a    = 1'b1;
					cmd.shift_e = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: tb/tb.sv
// Testbench for modular_exponentiation: directed and random bases, checked against a predictor.
`timescale 1ns / 100ps

module tb import mexp_pkg::*; ();

	localparam int W = DEF_WIDTH;
	// SETTLE covers one full-width exponent; STALL_LIMIT allows for SETTLE many times over
	localparam int SETTLE = 2 * W * W + 8 * W;
	localparam int STALL_LIMIT = 8 * SETTLE;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 23;

	typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	// Tracks the configuration and the queue of expected power_mod values
	class power_mod_tracker;
		logic [W-1:0] exponent;
		logic [W-1:0] modulus;
		logic [W-1:0] expected_powers[$];
		int errors;

		function new();
			exponent = '0;
			modulus = W'(1);
			errors = 0;
		endfunction

		// Mirror of a register write; a zero modulus is dropped
		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] value);
			case (idx)
				REG_EXPONENT: exponent = value;
				REG_MODULUS: begin
					if (value != '0)
						modulus = value;
				end
				default: ;
			endcase
		endfunction

		// base^exponent mod modulus at double width; zero exponent gives 1 unreduced
		function logic [W-1:0] power_of(input logic [W-1:0] b);
			logic [2*W-1:0] acc;
			logic [2*W-1:0] sq;
			logic [2*W-1:0] n;
			logic [W-1:0] e;
			if (exponent == '0)
				return W'(1);
			n = {{W{1'b0}}, modulus};
			acc = (2*W)'(1);
			sq = {{W{1'b0}}, b} % n;
			e = exponent;
			while (e != '0) begin
				if (e[0])
					acc = (acc * sq) % n;
				sq = (sq * sq) % n;
				e = e >> 1;
			end
			return acc[W-1:0];
		endfunction

		function void note_base(input logic [W-1:0] b);
			expected_powers.push_back(power_of(b));
		endfunction

		function int pending();
			return expected_powers.size();
		endfunction

		task report(input string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_power(input logic [W-1:0] got);
			logic [W-1:0] want;
			if (expected_powers.size() == 0) begin
				report($sformatf("power_mod %h with nothing expected", got));
			end else begin
				want = expected_powers.pop_front();
				if (got !== want)
					report($sformatf("power_mod %h, expected %h", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [W-1:0] wr_data;

	mexp_base_if #(.WIDTH(W)) req_if ();
	mexp_result_if #(.WIDTH(W)) rsp_if ();

	power_mod_tracker tracker = new();
	int send_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	modular_exponentiation #(.WIDTH(W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random backpressure on the result channel
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Monitor: mirror config writes, predict on base transfers, check result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				tracker.write_reg(wr_index, wr_data);
			if (req_if.valid && req_if.ready)
				tracker.note_base(req_if.base);
			if (rsp_if.valid && rsp_if.ready)
				tracker.check_power(rsp_if.power_mod);
		end
		if (wr_en || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
	end

	// Watchdog: too long without any transfer
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	task set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				send_pct = 0;
				stall_pct = 0;
			end
			PACE_SEND_IDLE: begin
				send_pct = 62;
				stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				send_pct = 0;
				stall_pct = 62;
			end
			default: begin
				send_pct = 14;
				stall_pct = 14;
			end
		endcase
	endtask

	// Register write: one cycle with wr_en high, then wr_en low again before the task returns
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task set_config(input logic [W-1:0] e, input logic [W-1:0] m);
		write_reg(REG_EXPONENT, e);
		write_reg(REG_MODULUS, m);
	endtask

	// Offer one base; valid stays high into the next item unless an idle gap comes
	task send_base(input logic [W-1:0] b);
		while ($urandom_range(0, 99) < send_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.base <= b;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	// Wait until every expected result has been transferred
	task drain();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	// Random base, biased toward zero, all ones and values around the modulus
	function logic [W-1:0] pick_base();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return tracker.modulus - W'(1);
			3: return tracker.modulus + W'($urandom_range(0, 3));
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		int p;
		logic [W-1:0] e;
		logic [W-1:0] m;

		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_EXPONENT;
		wr_data <= '0;
		req_if.valid <= 1'b0;
		req_if.base <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling
		set_pace(PACE_FREE);

		// Reset values: zero exponent with modulus one still gives 1
		send_base('0);
		send_base('1);
		send_base(W'(5));
		drain();

		// Modulus one with a nonzero exponent gives 0
		set_config(W'(1), W'(1));
		send_base(W'(7));
		send_base('1);
		drain();

		// Zero exponent with an ordinary modulus
		set_config('0, W'(1000));
		send_base(W'(12345));
		drain();

		// Squaring with the largest modulus; bases at and around it
		set_config(W'(2), '1);
		send_base('1);
		send_base('1 - W'(1));
		send_base('0);
		send_base(W'(1));
		send_base({1'b1, {(W-2){1'b0}}, 1'b1});
		drain();

		// All-ones exponent, modulus near the top; base above modulus
		set_config('1, '1 - W'(4));
		send_base(W'(2));
		send_base(W'(3));
		send_base('1 - W'(1));
		send_base('1);
		drain();

		// A zero modulus write is dropped; base equal to modulus gives 0
		write_reg(REG_MODULUS, '0);
		write_reg(REG_EXPONENT, W'(65537));
		send_base(W'(32'h1234_5678));
		send_base('1 - W'(4));
		send_base(W'(32'hDEAD_BEEF));
		drain();

		// Only the top exponent bit set, tiny modulus
		set_config({1'b1, {(W-1){1'b0}}}, W'(2));
		send_base(W'(3));
		send_base(W'(4));
		drain();

		// Random phases: idling pattern, exponent size and modulus kind rotate
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case ((p + p / 4) % 4)
				0: e = W'($urandom);
				1: e = W'($urandom_range(1, 255));
				2: e = W'($urandom_range(0, 15));
				default: e = W'($urandom_range(256, 65535));
			endcase
			case (p % 3)
				0: m = W'($urandom);
				1: m = W'($urandom_range(1, 1000));
				default: begin
					case (p / 3)
						0: m = '1;
						1: m = W'(1);
						2: m = W'(2);
						default: m = '1 - W'(4);
					endcase
				end
			endcase
			set_config(e, m);
			set_pace(pace_t'(p % 4));
			repeat (PHASE_ITEMS)
				send_base(pick_base());
			drain();
		end

		// Let any stray result show up before the verdict
		set_pace(PACE_FREE);
		repeat (SETTLE) @(posedge clk);
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
